// ----- rtl/s6d_pkg.sv -----
// ----------------------------------------------------------------------------
// s6d_pkg
// Shared types and constants for the six-bit character value decoder.
// ----------------------------------------------------------------------------
package s6d_pkg;

  localparam logic [7:0] LINE_FEED  = 8'd10;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [5:0] SIX_MASK   = 6'h3F;

  localparam int ITEM_W  = 13;
  localparam int VALUE_W = 24;
  localparam int CPV_W   = 3;
  localparam int CNT_W   = 17;  // limit compare width, covers the largest line limit

  // Configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_CHARS_PER_VALUE = 2'd0;
  localparam logic [1:0] REG_MAX_ITEMS       = 2'd1;
  localparam logic [1:0] REG_CHECKSUM_CHECK  = 2'd2;

  localparam logic [CPV_W-1:0]  CPV_RESET       = 3'd3;
  localparam logic [ITEM_W-1:0] MAX_ITEMS_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_VALUE     = 2'd0,
    KIND_LINE_END  = 2'd1,
    KIND_BLOCK_END = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CPV_W-1:0]  chars_per_value;
    logic [ITEM_W-1:0] max_items;
    logic              checksum_check;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       clear_carry;
  } word_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [ITEM_W-1:0]  line_items;
    logic               checksum_ok;
  } res_t;

endpackage

// ----- rtl/s6d_if.sv -----
// ----------------------------------------------------------------------------
// s6d_if
// Valid/ready channel interfaces for received bytes and decoded results.
// ----------------------------------------------------------------------------
interface s6d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       clear_carry;

  modport source (output valid, output rx_byte, output clear_carry, input ready);
  modport sink   (input valid, input rx_byte, input clear_carry, output ready);
endinterface

interface s6d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] value;
  logic [12:0] line_items;
  logic        checksum_ok;

  modport source (output valid, output kind, output value, output line_items,
                  output checksum_ok, input ready);
  modport sink   (input valid, input kind, input value, input line_items,
                  input checksum_ok, output ready);
endinterface

// ----- rtl/s6d_cfg.sv -----
// ----------------------------------------------------------------------------
// s6d_cfg
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module s6d_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output s6d_pkg::cfg_t     cfg
);
  import s6d_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chars_per_value <= CPV_RESET;
      cfg_r.max_items       <= MAX_ITEMS_RESET;
      cfg_r.checksum_check  <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CHARS_PER_VALUE: cfg_r.chars_per_value <= pwdata[CPV_W-1:0];
        REG_MAX_ITEMS:       cfg_r.max_items       <= pwdata[ITEM_W-1:0];
        REG_CHECKSUM_CHECK:  cfg_r.checksum_check  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHARS_PER_VALUE: prdata = {29'd0, cfg_r.chars_per_value};
      REG_MAX_ITEMS:       prdata = {19'd0, cfg_r.max_items};
      REG_CHECKSUM_CHECK:  prdata = {31'd0, cfg_r.checksum_check};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/s6d_core.sv -----
// ----------------------------------------------------------------------------
// s6d_core
// Line decoder state and the single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module s6d_core #(
  parameter int MAX_LINE_ITEMS = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  s6d_pkg::word_t word,
  input  s6d_pkg::cfg_t  cfg,
  output s6d_pkg::res_t  res
);
  import s6d_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(MAX_LINE_ITEMS);

  logic [7:0]         held_char_r, held_char_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [1:0]         dcnt_r, dcnt_nxt;
  logic [5:0]         sum_r, sum_nxt;
  logic [ITEM_W-1:0]  items_r, items_nxt;
  logic               ovf_r, ovf_nxt;

  logic [VALUE_W-1:0] acc0, acc_shift, mask;
  logic [1:0]         dcnt0;
  logic [2:0]         cpv, cnt;
  logic [5:0]         digit;
  logic [CNT_W-1:0]   limit;
  logic [7:0]         expect_char;
  logic               at_limit;

  // Clamp characters per value into 2..4
  always_comb begin
    unique case (cfg.chars_per_value)
      3'd0, 3'd1, 3'd2: begin cpv = 3'd2; mask = 24'h000FFF; end
      3'd3:             begin cpv = 3'd3; mask = 24'h03FFFF; end
      default:          begin cpv = 3'd4; mask = 24'hFFFFFF; end
    endcase
  end

  assign limit = (CNT_W'(cfg.max_items) < LIMIT_CAP) ? CNT_W'(cfg.max_items) : LIMIT_CAP;
  assign at_limit    = CNT_W'(items_r) >= limit;
  assign acc0        = word.clear_carry ? '0 : acc_r;
  assign dcnt0       = word.clear_carry ? 2'd0 : dcnt_r;
  assign digit       = 6'(held_char_r - DIGIT_BASE);
  assign acc_shift   = {acc0[VALUE_W-7:0], digit};
  assign cnt         = {1'b0, dcnt0} + 3'd1;
  assign expect_char = {2'b00, sum_r} + DIGIT_BASE;

  always_comb begin
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    acc_nxt        = acc0;
    dcnt_nxt       = dcnt0;
    sum_nxt        = sum_r;
    items_nxt      = items_r;
    ovf_nxt        = ovf_r;
    res            = '0;
    res.kind       = KIND_VALUE;

    if (word.rx_byte == LINE_FEED) begin
      // Line end: report unless the line already overflowed, then drop line state
      if (!ovf_r) begin
        res.valid = 1'b1;
        if (!held_valid_r) begin
          res.kind = KIND_BLOCK_END;
        end else begin
          res.kind        = KIND_LINE_END;
          res.line_items  = items_r;
          res.checksum_ok = !cfg.checksum_check || (expect_char == held_char_r);
        end
      end
      held_valid_nxt = 1'b0;
      held_char_nxt  = '0;
      sum_nxt        = '0;
      items_nxt      = '0;
      ovf_nxt        = 1'b0;
    end else if (!ovf_r) begin
      if (held_valid_r) begin
        acc_nxt = acc_shift;
        sum_nxt = sum_r + held_char_r[5:0];
        if (cnt >= cpv) begin
          dcnt_nxt  = 2'd0;
          res.valid = 1'b1;
          if (at_limit) begin
            ovf_nxt        = 1'b1;
            res.kind       = KIND_OVERFLOW;
            res.line_items = items_r;
          end else begin
            items_nxt      = items_r + 1'b1;
            res.value      = acc_shift & mask;
            res.line_items = items_r + 1'b1;
          end
        end else begin
          dcnt_nxt = cnt[1:0];
        end
      end
      if (ovf_nxt) begin
        held_valid_nxt = 1'b0;
        held_char_nxt  = '0;
      end else begin
        held_valid_nxt = 1'b1;
        held_char_nxt  = word.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      acc_r        <= '0;
      dcnt_r       <= '0;
      sum_r        <= '0;
      items_r      <= '0;
      ovf_r        <= 1'b0;
    end else if (advance) begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      acc_r        <= acc_nxt;
      dcnt_r       <= dcnt_nxt;
      sum_r        <= sum_nxt;
      items_r      <= items_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/six_bit_char_value_decoder_top.sv -----
// ----------------------------------------------------------------------------
// six_bit_char_value_decoder_top
// Decodes six-bit character encoded values from a line-based reply stream.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      rx_byte[7:0], clear_carry
//  out_ch   out  valid/ready      kind[1:0], value[23:0], line_items[12:0], checksum_ok
//  cfg      in   APB psel/penable chars_per_value @0x0, max_items @0x4, checksum_check @0x8
//
//  One word per cycle sustained unless a stalled result holds the input register.
//  A word is captured in the input register, then the decode logic updates the
//  line state and loads the result register, which drives result valid.
//  Reset (rst_n low, synchronous) clears the line state and loads register defaults.
//  A stalled result holds the input register only when the held word also
//  produces a result; words that produce nothing keep flowing.
// ----------------------------------------------------------------------------
module six_bit_char_value_decoder_top #(
  parameter int MAX_LINE_ITEMS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  s6d_in_if.sink      in_ch,
  s6d_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import s6d_pkg::*;

  cfg_t  cfg;
  word_t word_r;
  logic  word_v_r;
  res_t  res, res_r;
  logic  out_v_r, out_v_nxt;
  logic  advance;

  s6d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  s6d_core #(.MAX_LINE_ITEMS(MAX_LINE_ITEMS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (word_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Advance the held word unless it has a result and the output slot stays full
  assign advance     = word_v_r && (!res.valid || !out_v_r || out_ch.ready);
  assign in_ch.ready = !word_v_r || advance;
  assign out_v_nxt   = (out_v_r && !out_ch.ready) || (advance && res.valid);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      word_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      word_r.rx_byte     <= in_ch.rx_byte;
      word_r.clear_carry <= in_ch.clear_carry;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.value       = res_r.value;
  assign out_ch.line_items  = res_r.line_items;
  assign out_ch.checksum_ok = res_r.checksum_ok;

  // Only a decoded value carries a nonzero value field
  a_value_only_for_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.kind != KIND_VALUE)) |-> (res_r.value == '0))
    else $error("value field set on a non-value result");

  // Checksum flag only on a line end
  a_ok_only_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.checksum_ok) |-> (res_r.kind == KIND_LINE_END))
    else $error("checksum_ok set outside a line end");

  // A block end reports no items
  a_block_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.kind == KIND_BLOCK_END)) |-> (res_r.line_items == '0))
    else $error("block end with nonzero item count");

  // A held word that cannot advance stays put
  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (word_v_r && !advance) |=> (word_v_r && $stable(word_r)))
    else $error("input register lost a stalled word");

endmodule

// ----- verif/six_bit_char_value_decoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_bit_char_value_decoder_top_test
// Self-checking bench for the six-bit character value decoder. It sends reply
// lines (data, checksum, line feed), empty lines and noise over the byte
// channel under several register settings and idle patterns. It predicts every
// result word and checks each field against the oldest prediction.
// ----------------------------------------------------------------------------
import s6d_pkg::*;

typedef struct {
  kind_t              kind;
  logic [VALUE_W-1:0] value;
  logic [ITEM_W-1:0]  line_items;
  logic               checksum_ok;
} decode_result_t;

typedef logic [7:0] char_q_t[$];

class line_decoder_scoreboard;
  int                 item_cap;
  logic [CPV_W-1:0]   chars_per_value;
  logic [ITEM_W-1:0]  max_items;
  logic               checksum_check;
  logic [7:0]         held_char;
  bit                 held_valid;
  logic [VALUE_W-1:0] accum;
  logic [1:0]         digit_count;
  logic [5:0]         line_sum;
  logic [ITEM_W-1:0]  item_count;
  bit                 overflowed;
  decode_result_t     pending_results[$];
  int                 errors;

  function new(int cap);
    item_cap        = cap;
    chars_per_value = CPV_RESET;
    max_items       = MAX_ITEMS_RESET;
    checksum_check  = 1'b1;
    accum           = '0;
    digit_count     = '0;
    errors          = 0;
    clear_line();
  endfunction

  function void clear_line();
    held_char  = '0;
    held_valid = 1'b0;
    line_sum   = '0;
    item_count = '0;
    overflowed = 1'b0;
  endfunction

  function void write_reg(logic [1:0] index, logic [31:0] data);
    case (index)
      REG_CHARS_PER_VALUE: chars_per_value = data[CPV_W-1:0];
      REG_MAX_ITEMS:       max_items = data[ITEM_W-1:0];
      REG_CHECKSUM_CHECK:  checksum_check = data[0];
      default: ;
    endcase
  endfunction

  // Advance the line state by one accepted word and queue the result it causes.
  function void decode_char(logic [7:0] rx_byte, logic clear_carry);
    decode_result_t r;
    int             cpv;
    int             lim;
    int             cnt;
    logic [5:0]     digit;
    logic [7:0]     sum_char;
    r.kind        = KIND_VALUE;
    r.value       = '0;
    r.line_items  = '0;
    r.checksum_ok = 1'b0;
    if (clear_carry) begin
      accum       = '0;
      digit_count = '0;
    end
    if (rx_byte == LINE_FEED) begin
      if (!overflowed) begin
        if (held_valid) begin
          sum_char      = {2'b00, line_sum} + DIGIT_BASE;
          r.kind        = KIND_LINE_END;
          r.line_items  = item_count;
          r.checksum_ok = !checksum_check || (sum_char == held_char);
        end else begin
          r.kind = KIND_BLOCK_END;
        end
        pending_results.push_back(r);
      end
      clear_line();
      return;
    end
    if (overflowed) return;
    if (held_valid) begin
      cpv = (chars_per_value < 2) ? 2 : (chars_per_value > 4) ? 4 : int'(chars_per_value);
      lim = (int'(max_items) > item_cap) ? item_cap : int'(max_items);
      digit    = held_char[5:0] - DIGIT_BASE[5:0];
      accum    = {accum[VALUE_W-7:0], digit};
      line_sum = line_sum + held_char[5:0];
      cnt      = digit_count + 1;
      if (cnt >= cpv) begin
        digit_count = '0;
        if (item_count >= lim) begin
          overflowed   = 1'b1;
          r.kind       = KIND_OVERFLOW;
          r.line_items = item_count;
        end else begin
          item_count   = item_count + 1'b1;
          r.line_items = item_count;
          r.value      = accum & ({VALUE_W{1'b1}} >> (6 * (4 - cpv)));
        end
        pending_results.push_back(r);
      end else begin
        digit_count = cnt[1:0];
      end
    end
    if (overflowed) begin
      held_valid = 1'b0;
      held_char  = '0;
    end else begin
      held_char  = rx_byte;
      held_valid = 1'b1;
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [VALUE_W-1:0] value,
                             logic [ITEM_W-1:0] items, logic ok);
    decode_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word kind %0d value %h items %0d ok %0d",
               $time, kind, value, items, ok);
      return;
    end
    want = pending_results.pop_front();
    if (kind !== want.kind || value !== want.value || items !== want.line_items ||
        ok !== want.checksum_ok) begin
      errors++;
      $display("%0t: expected kind/value/items/ok %0d/%h/%0d/%0d, got %0d/%h/%0d/%0d",
               $time, want.kind, want.value, want.line_items, want.checksum_ok,
               kind, value, items, ok);
    end
  endfunction
endclass

module six_bit_char_value_decoder_top_test;
  localparam int LINE_ITEM_CAP  = 4096;
  localparam int STALL_LIMIT    = 4000;  // cycles with no word moving on either channel
  localparam int HOLDOFF_CYCLES = 250;
  localparam int SETTLE_CYCLES  = 6;     // well past the input and result registers

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  s6d_in_if  in_ch();
  s6d_out_if out_ch();

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int clear_pct      = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  bit holdoff_req    = 1'b0;

  line_decoder_scoreboard sb = new(LINE_ITEM_CAP);

  six_bit_char_value_decoder_top #(.MAX_LINE_ITEMS(LINE_ITEM_CAP)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: stall at random, or hold off for a long stretch on request so
  // the block backs up and drops in_ch.ready while the sender keeps offering.
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left = holdoff_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Check every result word at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.value, out_ch.line_items, out_ch.checksum_ok);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_idle(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Offer one word, idling first at random; note it once the handshake lands.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_byte(input logic [7:0] rx_byte, input logic clear_carry);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= rx_byte;
    in_ch.clear_carry <= clear_carry;
    do @(posedge clk); while (!in_ch.ready);
    sb.decode_char(rx_byte, clear_carry);
    bytes_sent++;
  endtask

  // Send data chars, then the checksum char (flipped in one bit when bad), then LF.
  task automatic send_line(input char_q_t data, input bit good, input bit clear_first);
    logic [5:0] sum;
    logic [7:0] sum_char;
    sum = '0;
    foreach (data[i]) begin
      send_byte(data[i], (i == 0) ? clear_first : ($urandom_range(99) < clear_pct));
      sum = sum + data[i][5:0];
    end
    sum_char = {2'b00, sum} + DIGIT_BASE;
    if (!good)
      sum_char = sum_char ^ (8'd1 << $urandom_range(5));
    send_byte(sum_char, (data.size() == 0) ? clear_first : ($urandom_range(99) < clear_pct));
    send_byte(LINE_FEED, $urandom_range(99) < clear_pct);
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == LINE_FEED);
    return c;
  endfunction

  function automatic logic [ITEM_W-1:0] random_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ITEM_W'($urandom_range(1, 4));
      2:       return ITEM_W'($urandom_range(5, 40));
      3:       return MAX_ITEMS_RESET;
      4:       return ITEM_W'($urandom_range(4097, 8191));
      default: return ITEM_W'($urandom_range(41, 4095));
    endcase
  endfunction

  task automatic send_random_line();
    char_q_t data;
    int      n;
    n = ($urandom_range(9) == 0) ? $urandom_range(21, 90) : $urandom_range(0, 20);
    repeat (n)
      data.push_back(($urandom_range(9) == 0) ? any_char() :
                     DIGIT_BASE + 8'($urandom_range(63)));
    send_line(data, $urandom_range(4) != 0, $urandom_range(19) == 0);
  endtask

  // Mostly well-formed lines; the rest bare line feeds and raw noise bursts.
  task automatic run_random(input int n_bytes);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 8)
        send_byte(LINE_FEED, $urandom_range(99) < clear_pct);
      else if (pick < 16)
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        send_random_line();
    end
  endtask

  // Drop valid, wait for every predicted word, then let silent words drain.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access; the register takes the value at the edge with pready high.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(index, data);
  endtask

  task automatic apply_config(input logic [CPV_W-1:0] cpv, input logic [ITEM_W-1:0] limit,
                              input logic check_en);
    drain();
    write_reg(REG_CHARS_PER_VALUE, 32'(cpv));
    write_reg(REG_MAX_ITEMS, 32'(limit));
    write_reg(REG_CHECKSUM_CHECK, 32'(check_en));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    char_q_t line;
    int      p;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.rx_byte     <= '0;
    in_ch.clear_carry <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under reset settings (three chars per value, checks on).
    // A bare line feed with nothing held closes a block.
    send_byte(LINE_FEED, 1'b0);
    // Single character lines: the char is the checksum of no data.
    line.delete();
    send_line(line, 1'b1, 1'b0);
    send_line(line, 1'b0, 1'b0);
    // Largest digits give the widest value at this setting.
    line = '{8'h6F, 8'h6F, 8'h6F};
    send_line(line, 1'b1, 1'b0);
    // Chars outside the digit range wrap modulo 64; one digit carries over.
    line = '{8'h00, 8'hFF, 8'h2F, 8'h70};
    send_line(line, 1'b1, 1'b0);
    // Clear the carry right as a held char is about to decode.
    send_byte(8'h32, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(LINE_FEED, 1'b0);
    // Leave two digits pending, then lower chars per value to that count.
    line = '{8'h41, 8'h42};
    send_line(line, 1'b1, 1'b0);

    // Smallest values and limit, checksum off: nearly every line overflows.
    apply_config(3'd2, 13'd1, 1'b0);
    set_idle(63, 0);
    clear_pct = 3;
    run_random(150);

    // Widest values; limit above the line cap. Hold the result side off.
    apply_config(3'd4, 13'd8191, 1'b1);
    set_idle(0, 63);
    line = '{8'h6F, 8'h6F, 8'h6F, 8'h6F};
    send_line(line, 1'b1, 1'b1);
    holdoff_req = 1'b1;
    run_random(150);

    // Below-range chars per value and a zero limit.
    apply_config(3'd0, 13'd0, 1'b1);
    set_idle(27, 27);
    run_random(150);

    // Above-range chars per value and a small limit.
    apply_config(3'd7, 13'd3, 1'b0);
    set_idle(0, 0);
    run_random(150);

    // Random settings, cycling through the idle patterns.
    for (p = 0; p < 8; p++) begin
      apply_config(CPV_W'($urandom_range(7)), random_limit(), 1'($urandom_range(1)));
      case (p % 4)
        0:       set_idle(0, 0);
        1:       set_idle(63, 0);
        2:       set_idle(0, 63);
        default: set_idle(27, 27);
      endcase
      run_random(140);
    end

    // Back to the reset values.
    apply_config(CPV_RESET, MAX_ITEMS_RESET, 1'b1);
    set_idle(0, 0);
    run_random(100);

    drain();
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
